// ----- hdl/gmsa_pkg.sv -----
// Shared types, constants and status codes for the grouped statistics unit.
package gmsa_pkg;

  localparam int SUM_W = 40;
  localparam int SQ_W  = 62;
  localparam int VAL_W = 24;
  localparam int NLANE = 4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic OP_ACC   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic CFG_ZONE_BASE = 1'b0;
  localparam logic CFG_CELL_BASE = 1'b1;

  typedef logic signed [SUM_W-1:0] sum_t;
  typedef logic [SQ_W-1:0] sq_t;

  // Handshake from the top level to the lane statistics units.
  typedef struct packed {
    logic        start;
    logic [16:0] count;
  } lane_ctl_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] mean;
    logic [VAL_W-1:0]        sd;
  } lane_res_t;

endpackage

// ----- hdl/grouped_mean_stddev_accumulator_unit.sv -----
// Top level: store, window check, accumulate path and lane merge for queries.
//
//  channel  | ports                                             | timing
//  cmd in   | start/busy, opcode, zone_id, cell_id, whole_zone, | taken at start && !busy
//           | x_offset, y_offset, z_offset, dist_value          |
//  result   | done + status, entry_count, mean_*, sd_*          | one cycle strobe
//  config   | cfg_we, cfg_index, cfg_data                       | written when cfg_we
//
// After reset a clearing pass sweeps all cells with busy high.
// An accumulate steps through read, add and write back (states S_RD, S_UPD).
// An out-of-window word is answered in the next cycle and busy stays low.
// A query on a non-empty entry spends most of its time in the bit-serial multiply, divide and root in the lanes.
// Results cannot be stalled; the next command is taken once busy falls.
module grouped_mean_stddev_accumulator_unit import gmsa_pkg::*; #(
  parameter int NUM_ZONES      = 16,
  parameter int CELLS_PER_ZONE = 64,
  parameter int MAX_COUNT      = 65535
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               opcode,
  input  logic [15:0]        zone_id,
  input  logic [15:0]        cell_id,
  input  logic               whole_zone,
  input  logic signed [23:0] x_offset,
  input  logic signed [23:0] y_offset,
  input  logic signed [23:0] z_offset,
  input  logic [22:0]        dist_value,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data,
  output logic               done,
  output logic [1:0]         status,
  output logic [15:0]        entry_count,
  output logic signed [23:0] mean_x,
  output logic signed [23:0] mean_y,
  output logic signed [23:0] mean_z,
  output logic [22:0]        mean_dist,
  output logic [23:0]        sd_x,
  output logic [23:0]        sd_y,
  output logic [23:0]        sd_z,
  output logic [22:0]        sd_dist
);

  localparam int ZW    = (NUM_ZONES > 1) ? $clog2(NUM_ZONES) : 1;
  localparam int CW    = (CELLS_PER_ZONE > 1) ? $clog2(CELLS_PER_ZONE) : 1;
  localparam int NCELL = NUM_ZONES * CELLS_PER_ZONE;
  localparam int EW    = (NCELL > 1) ? $clog2(NCELL) : 1;
  localparam int MEMW  = 16 + NLANE * (SUM_W + SQ_W);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_UPD  = 3'd3;
  localparam logic [2:0] S_QRY  = 3'd4;
  localparam logic [2:0] S_WAIT = 3'd5;

  logic [2:0]  state;
  logic [15:0] zone_base;
  logic [15:0] cell_base;
  logic [EW:0] clr_idx;

  logic [MEMW-1:0] cell_mem [NCELL];
  logic [MEMW-1:0] zone_mem [NUM_ZONES];
  logic [MEMW-1:0] cell_rd;
  logic [MEMW-1:0] zone_rd;

  logic [ZW-1:0] zi;
  logic [EW-1:0] ei;
  logic          whole;
  logic          op;
  logic signed [SUM_W-1:0] val [NLANE];
  logic [SQ_W-1:0]         vsq [NLANE];

  logic [15:0] zoff;
  logic [15:0] coff;
  logic        zone_ok;
  logic        cell_ok;

  logic [MEMW-1:0] cell_new;
  logic [MEMW-1:0] zone_new;
  logic [MEMW-1:0] q_ent;
  logic            full;

  lane_ctl_t ctl;
  logic      lane_done [NLANE];
  lane_res_t lane_res  [NLANE];

  assign zoff    = zone_id - zone_base;
  assign coff    = cell_id - cell_base;
  assign zone_ok = (zone_id >= zone_base) && (17'(zoff) < 17'(NUM_ZONES));
  assign cell_ok = (cell_id >= cell_base) && (17'(coff) < 17'(CELLS_PER_ZONE));
  assign busy    = (state != S_IDLE);

  always_comb begin
    cell_new = cell_rd;
    zone_new = zone_rd;
    cell_new[15:0] = cell_rd[15:0] + 16'd1;
    zone_new[15:0] = zone_rd[15:0] + 16'd1;
    for (int k = 0; k < NLANE; k++) begin
      cell_new[16 + k*(SUM_W+SQ_W) +: SUM_W] =
        cell_rd[16 + k*(SUM_W+SQ_W) +: SUM_W] + val[k];
      cell_new[16 + k*(SUM_W+SQ_W) + SUM_W +: SQ_W] =
        cell_rd[16 + k*(SUM_W+SQ_W) + SUM_W +: SQ_W] + vsq[k];
      zone_new[16 + k*(SUM_W+SQ_W) +: SUM_W] =
        zone_rd[16 + k*(SUM_W+SQ_W) +: SUM_W] + val[k];
      zone_new[16 + k*(SUM_W+SQ_W) + SUM_W +: SQ_W] =
        zone_rd[16 + k*(SUM_W+SQ_W) + SUM_W +: SQ_W] + vsq[k];
    end
    q_ent = whole ? zone_rd : cell_rd;
    full  = (zone_rd[15:0] >= 16'(MAX_COUNT)) || (cell_rd[15:0] >= 16'(MAX_COUNT));
  end

  // Memories: one read and one write port each, read data registered.
  always_ff @(posedge clk) begin
    cell_rd <= cell_mem[ei];
    zone_rd <= zone_mem[zi];
    if (state == S_CLR) begin
      cell_mem[clr_idx[EW-1:0]] <= '0;
      if (clr_idx < (EW+1)'(NUM_ZONES))
        zone_mem[clr_idx[ZW-1:0]] <= '0;
    end else if (state == S_UPD && !full) begin
      cell_mem[ei] <= cell_new;
      zone_mem[zi] <= zone_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_idx   <= '0;
      zone_base <= '0;
      cell_base <= '0;
      done      <= 1'b0;
      ctl.start <= 1'b0;
    end else begin
      done      <= 1'b0;
      ctl.start <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == CFG_ZONE_BASE) zone_base <= cfg_data;
        else                            cell_base <= cfg_data;
      end
      case (state)
        S_CLR: begin
          clr_idx <= clr_idx + (EW+1)'(1);
          if (clr_idx == (EW+1)'(NCELL - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            zi    <= ZW'(zoff);
            ei    <= EW'(zoff) * EW'(CELLS_PER_ZONE) + EW'(coff);
            whole <= whole_zone;
            op    <= opcode;
            val[0] <= SUM_W'(x_offset);
            val[1] <= SUM_W'(y_offset);
            val[2] <= SUM_W'(z_offset);
            val[3] <= SUM_W'($signed({1'b0, dist_value}));
            vsq[0] <= SQ_W'(48'(x_offset) * 48'(x_offset));
            vsq[1] <= SQ_W'(48'(y_offset) * 48'(y_offset));
            vsq[2] <= SQ_W'(48'(z_offset) * 48'(z_offset));
            vsq[3] <= SQ_W'({25'd0, dist_value} * {25'd0, dist_value});
            if (!zone_ok || (!(opcode == OP_QUERY && whole_zone) && !cell_ok)) begin
              done <= 1'b1;
              status <= ST_RANGE;
              entry_count <= '0;
              mean_x <= '0; mean_y <= '0; mean_z <= '0; mean_dist <= '0;
              sd_x <= '0; sd_y <= '0; sd_z <= '0; sd_dist <= '0;
            end else begin
              state <= S_RD;
            end
          end
        end
        S_RD: state <= (op == OP_ACC) ? S_UPD : S_QRY;
        S_UPD: begin
          done <= 1'b1;
          status <= full ? ST_FULL : ST_OK;
          entry_count <= '0;
          mean_x <= '0; mean_y <= '0; mean_z <= '0; mean_dist <= '0;
          sd_x <= '0; sd_y <= '0; sd_z <= '0; sd_dist <= '0;
          state <= S_IDLE;
        end
        S_QRY: begin
          entry_count <= q_ent[15:0];
          if (q_ent[15:0] == '0) begin
            done <= 1'b1;
            status <= ST_OK;
            mean_x <= '0; mean_y <= '0; mean_z <= '0; mean_dist <= '0;
            sd_x <= '0; sd_y <= '0; sd_z <= '0; sd_dist <= '0;
            state <= S_IDLE;
          end else begin
            ctl.start <= 1'b1;
            ctl.count <= 17'(q_ent[15:0]);
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          // lanes run in lockstep, so lane zero marks completion of all
          if (lane_done[0]) begin
            done <= 1'b1;
            status <= ST_OK;
            mean_x <= lane_res[0].mean;
            mean_y <= lane_res[1].mean;
            mean_z <= lane_res[2].mean;
            mean_dist <= lane_res[3].mean[22:0];
            sd_x <= lane_res[0].sd;
            sd_y <= lane_res[1].sd;
            sd_z <= lane_res[2].sd;
            sd_dist <= lane_res[3].sd[22:0];
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  for (genvar k = 0; k < NLANE; k++) begin : g_lane
    gmsa_lane u_lane (
      .clk   (clk),
      .rst   (rst),
      .ctl   (ctl),
      .sum   (q_ent[16 + k*(SUM_W+SQ_W) +: SUM_W]),
      .sumsq (q_ent[16 + k*(SUM_W+SQ_W) + SUM_W +: SQ_W]),
      .done  (lane_done[k]),
      .res   (lane_res[k])
    );
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !$past(state == S_CLR)) else $error("result during clearing pass");
  a_lane_sync: assert property (@(posedge clk) disable iff (rst)
    lane_done[0] |-> lane_done[3]) else $error("lanes out of step");
  a_status: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == ST_OK || status == ST_RANGE || status == ST_FULL))
    else $error("bad status code");

endmodule

// ----- hdl/gmsa_lane.sv -----
// One statistics lane: takes one element's sum and sum of squares and computes its mean and deviation.
module gmsa_lane import gmsa_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  lane_ctl_t ctl,
  input  sum_t      sum,
  input  sq_t       sumsq,
  output logic      done,
  output lane_res_t res
);

  // Phases of the lane sequencer.
  localparam logic [2:0] P_IDLE = 3'd0;
  localparam logic [2:0] P_MUL  = 3'd1;
  localparam logic [2:0] P_SUB  = 3'd2;
  localparam logic [2:0] P_DIV  = 3'd3;
  localparam logic [2:0] P_SQRT = 3'd4;

  logic [2:0]   phase;
  logic [6:0]   step;
  logic [16:0]  n;
  logic [31:0]  nn;
  logic [39:0]  smag;
  logic         sneg;
  logic [61:0]  sq;
  logic [79:0]  p_a;
  logic [79:0]  p_b;
  logic [80:0]  num;
  logic [32:0]  rem;
  logic [63:0]  quo;
  logic [39:0]  mrem;
  logic [39:0]  mquo;
  logic [63:0]  rv;
  logic [63:0]  rr;
  logic [63:0]  rbit;
  logic         ovf;

  logic [32:0]  rem_sh;
  logic [40:0]  mrem_sh;
  logic [63:0]  rtry;

  assign rem_sh  = {rem[31:0], num[80]};
  assign mrem_sh = {mrem, mquo[39]};
  assign rtry    = rr + rbit;

  // Both products are shift-and-add, one bit per step: n*sq over the 17 bits of n, and
  // the 40x40 square s*s alongside it.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (phase)
        P_IDLE: begin
          if (ctl.start) begin
            n     <= ctl.count;
            nn    <= 32'(ctl.count) * 32'(ctl.count);
            sneg  <= sum[SUM_W-1];
            smag  <= sum[SUM_W-1] ? 40'(-sum) : 40'(sum);
            sq    <= sumsq;
            p_a   <= '0;
            p_b   <= '0;
            step  <= '0;
            phase <= P_MUL;
          end
        end
        P_MUL: begin
          // one bit of s*s per cycle, and one bit of n*sq over the 17 bits of n
          if (step < 7'd17 && n[step[4:0]])
            p_a <= p_a + (80'(sq) << step);
          if (smag[step[5:0]])
            p_b <= p_b + (80'(smag) << step);
          step <= step + 7'd1;
          if (step == 7'd39) phase <= P_SUB;
        end
        P_SUB: begin
          num   <= (p_a >= p_b) ? 81'(p_a - p_b) : '0;
          rem   <= '0;
          quo   <= '0;
          mrem  <= '0;
          mquo  <= smag;
          ovf   <= 1'b0;
          step  <= '0;
          phase <= P_DIV;
        end
        P_DIV: begin
          // restoring divides: variance by n*n and mean by n, one bit a cycle
          num <= num << 1;
          if (rem_sh >= 33'(nn)) begin
            rem <= rem_sh - 33'(nn);
            if (step < 7'd17 && 1'b1) ovf <= 1'b1;
            quo <= {quo[62:0], 1'b1};
          end else begin
            rem <= rem_sh;
            quo <= {quo[62:0], 1'b0};
          end
          if (step < 7'd40) begin
            mquo <= {mquo[38:0], (mrem_sh >= 41'(n))};
            mrem <= (mrem_sh >= 41'(n)) ? 40'(mrem_sh - 41'(n)) : mrem_sh[39:0];
          end
          step <= step + 7'd1;
          if (step == 7'd80) begin
            phase <= P_SQRT;
          end
        end
        P_SQRT: begin
          if (step == 7'd81) begin
            rv   <= ovf ? '1 : quo;
            rr   <= '0;
            rbit <= 64'd1 << 62;
            step <= '0;
          end else begin
            if (rbit != '0) begin
              if (rv >= rtry) begin
                rv <= rv - rtry;
                rr <= (rr >> 1) + rbit;
              end else begin
                rr <= rr >> 1;
              end
              rbit <= rbit >> 2;
            end else begin
              res.mean <= sneg ? VAL_W'(-mquo) : VAL_W'(mquo);
              res.sd   <= rr[VAL_W-1:0];
              done     <= 1'b1;
              phase    <= P_IDLE;
            end
          end
        end
        default: phase <= P_IDLE;
      endcase
    end
  end

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the grouped mean and standard deviation unit.
`timescale 1ns / 1ps

module testbench;
  import gmsa_pkg::*;

  localparam int ZONES = 16;
  localparam int CELLS = 64;
  localparam int MAX_N = 65535;

  typedef struct {
    logic [1:0]  status;
    logic [15:0] cnt;
    logic [23:0] mean [4];
    logic [23:0] sd [4];
  } stats_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic opcode = OP_ACC;
  logic [15:0] zone_id = '0;
  logic [15:0] cell_id = '0;
  logic whole_zone = 1'b0;
  logic signed [23:0] x_offset = '0;
  logic signed [23:0] y_offset = '0;
  logic signed [23:0] z_offset = '0;
  logic [22:0] dist_value = '0;
  logic cfg_we = 1'b0;
  logic cfg_index = CFG_ZONE_BASE;
  logic [15:0] cfg_data = '0;
  logic done;
  logic [1:0] status;
  logic [15:0] entry_count;
  logic signed [23:0] mean_x, mean_y, mean_z;
  logic [22:0] mean_dist;
  logic [23:0] sd_x, sd_y, sd_z;
  logic [22:0] sd_dist;

  grouped_mean_stddev_accumulator_unit dut (.*);

  // Shadow copy of the statistics store and the window registers.
  bit [15:0] zbase, cbase;
  int unsigned cell_n [ZONES*CELLS];
  int unsigned zone_n [ZONES];
  longint cell_sum [ZONES*CELLS*4];
  bit [63:0] cell_sq [ZONES*CELLS*4];
  longint zone_sum [ZONES*4];
  bit [63:0] zone_sq [ZONES*4];

  stats_word_t expected_q [$];
  int errors = 0;
  int n_acc = 0, n_query = 0, n_range = 0, n_full = 0, n_checked = 0;
  int burst_left = 0;
  bit no_gaps = 1'b0;

  initial forever #4 clk = ~clk;

  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic bit [63:0] int_sqrt(bit [63:0] v);
    bit [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // floor((n*sq - s*s) / n^2), saturated to 64 bits
  function automatic bit [63:0] variance_of(longint n, longint s, bit [63:0] sq);
    bit [127:0] nw, mw, a, b, q;
    nw = n;
    mw = (s < 0) ? -s : s;
    a = nw * sq;
    b = mw * mw;
    if (a < b) return 0;
    q = (a - b) / (nw * nw);
    if (q[127:64] != 0) return '1;
    return q[63:0];
  endfunction

  function automatic stats_word_t predict_word(logic op, logic [15:0] zid, logic [15:0] cid,
      logic whole, logic signed [23:0] x, logic signed [23:0] y, logic signed [23:0] z,
      logic [22:0] d);
    stats_word_t w;
    int zi, ci, e, k;
    bit zok, cok;
    longint v [4];
    longint n, s, m;
    bit [63:0] sq, sqs;
    w.status = ST_OK;
    w.cnt = '0;
    for (k = 0; k < 4; k++) begin
      w.mean[k] = '0;
      w.sd[k] = '0;
    end
    zi = int'(zid) - int'(zbase);
    ci = int'(cid) - int'(cbase);
    zok = zi >= 0 && zi < ZONES;
    cok = ci >= 0 && ci < CELLS;
    if (op == OP_ACC) begin
      n_acc++;
      if (!zok || !cok) begin
        w.status = ST_RANGE;
        return w;
      end
      e = zi * CELLS + ci;
      if (zone_n[zi] >= MAX_N || cell_n[e] >= MAX_N) begin
        w.status = ST_FULL;
        return w;
      end
      v[0] = x; v[1] = y; v[2] = z; v[3] = longint'({1'b0, d});
      zone_n[zi]++;
      cell_n[e]++;
      for (k = 0; k < 4; k++) begin
        m = (v[k] < 0) ? -v[k] : v[k];
        sq = m * m;
        zone_sum[zi*4+k] += v[k];
        zone_sq[zi*4+k] += sq;
        cell_sum[e*4+k] += v[k];
        cell_sq[e*4+k] += sq;
      end
      return w;
    end
    n_query++;
    if (!zok || (!whole && !cok)) begin
      w.status = ST_RANGE;
      return w;
    end
    e = zi * CELLS + ci;
    n = whole ? zone_n[zi] : cell_n[e];
    w.cnt = n[15:0];
    if (n == 0) return w;
    for (k = 0; k < 4; k++) begin
      s = whole ? zone_sum[zi*4+k] : cell_sum[e*4+k];
      sqs = whole ? zone_sq[zi*4+k] : cell_sq[e*4+k];
      w.mean[k] = 24'(s / n);
      w.sd[k] = 24'(int_sqrt(variance_of(n, s, sqs)));
      // The distance lane is only 23 bits wide.
      if (k == 3) begin
        w.mean[k][23] = 1'b0;
        w.sd[k][23] = 1'b0;
      end
    end
    return w;
  endfunction

  function automatic void check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && done) begin
      stats_word_t w;
      logic [23:0] got_mean [4];
      logic [23:0] got_sd [4];
      got_mean = '{mean_x, mean_y, mean_z, {1'b0, mean_dist}};
      got_sd = '{sd_x, sd_y, sd_z, {1'b0, sd_dist}};
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result word with none expected, status %0d", $time, status);
      end else begin
        w = expected_q.pop_front();
        n_checked++;
        check_field("status", w.status, status);
        check_field("entry_count", w.cnt, entry_count);
        for (int k = 0; k < 4; k++) begin
          check_field($sformatf("mean[%0d]", k), w.mean[k], got_mean[k]);
          check_field($sformatf("sd[%0d]", k), w.sd[k], got_sd[k]);
        end
      end
    end
  end

  task automatic send_word(logic op, logic [15:0] zid, logic [15:0] cid, logic whole,
      logic signed [23:0] x, logic signed [23:0] y, logic signed [23:0] z, logic [22:0] d);
    stats_word_t w;
    int gap;
    if (!no_gaps) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          @(negedge clk);
          start = 1'b0;
          repeat (gap - 1) @(negedge clk);
        end
      end
      burst_left--;
    end
    @(negedge clk);
    start = 1'b1;
    opcode = op;
    zone_id = zid;
    cell_id = cid;
    whole_zone = whole;
    x_offset = x;
    y_offset = y;
    z_offset = z;
    dist_value = d;
    do @(posedge clk); while (busy);
    w = predict_word(op, zid, cid, whole, x, y, z, d);
    if (w.status == ST_RANGE) n_range++;
    if (w.status == ST_FULL) n_full++;
    expected_q.insert(expected_q.size(), w);
  endtask

  // Holds the sender off until every outstanding word has come back.
  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (expected_q.size() != 0 || busy) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] value);
    drain();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CFG_ZONE_BASE) zbase = value;
    else cbase = value;
  endtask

  task automatic set_window(logic [15:0] zb, logic [15:0] cb);
    write_reg(CFG_ZONE_BASE, zb);
    write_reg(CFG_CELL_BASE, cb);
  endtask

  task automatic test_windows_and_extremes();
    set_window(16'd0, 16'd0);
    send_word(OP_QUERY, 16'd3, 16'd5, 1'b0, 0, 0, 0, 0);
    send_word(OP_QUERY, 16'd3, 16'd5, 1'b1, 0, 0, 0, 0);
    send_word(OP_ACC, 16'd0, 16'd0, 1'b0, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 23'h7FFFFF);
    send_word(OP_ACC, 16'd0, 16'd0, 1'b1, 24'sh800000, 24'sh7FFFFF, -24'sd1, 23'h0);
    send_word(OP_ACC, 16'd0, 16'd63, 1'b0, -24'sd3, 24'sd5, 24'sd0, 23'd7);
    send_word(OP_QUERY, 16'd0, 16'd0, 1'b0, 24'sh7FFFFF, 0, 0, 23'h7FFFFF);
    send_word(OP_QUERY, 16'd0, 16'hFFFF, 1'b1, 0, 0, 0, 0);
    send_word(OP_ACC, 16'd16, 16'd0, 1'b0, 1, 1, 1, 1);
    send_word(OP_ACC, 16'd15, 16'd64, 1'b0, 1, 1, 1, 1);
    send_word(OP_QUERY, 16'd16, 16'd0, 1'b1, 0, 0, 0, 0);
    send_word(OP_QUERY, 16'd0, 16'd64, 1'b0, 0, 0, 0, 0);
    set_window(16'd100, 16'd200);
    send_word(OP_ACC, 16'd99, 16'd200, 1'b0, 1, 2, 3, 4);
    send_word(OP_ACC, 16'd116, 16'd200, 1'b0, 1, 2, 3, 4);
    send_word(OP_ACC, 16'd100, 16'd199, 1'b0, 1, 2, 3, 4);
    send_word(OP_ACC, 16'd100, 16'd264, 1'b0, 1, 2, 3, 4);
    send_word(OP_ACC, 16'd115, 16'd263, 1'b0, -24'sd4096, 24'sd4096, 24'sd9, 23'd4096);
    send_word(OP_ACC, 16'd115, 16'd263, 1'b0, 24'sd4096, -24'sd4096, -24'sd9, 23'd0);
    send_word(OP_QUERY, 16'd115, 16'd263, 1'b0, 0, 0, 0, 0);
    send_word(OP_QUERY, 16'd115, 16'd0, 1'b1, 0, 0, 0, 0);
    send_word(OP_QUERY, 16'd100, 16'd200, 1'b0, 0, 0, 0, 0);
    drain();
  endtask

  task automatic random_phase(logic [15:0] zb, logic [15:0] cb, int count);
    logic op, whole;
    logic [15:0] zid, cid;
    logic signed [23:0] x, y, z;
    logic [22:0] d;
    set_window(zb, cb);
    repeat (count) begin
      op = ($urandom_range(0, 3) == 0) ? OP_QUERY : OP_ACC;
      whole = 1'($urandom);
      zid = ($urandom_range(0, 99) < 88) ? 16'(zb + $urandom_range(0, ZONES - 1))
                                         : 16'($urandom);
      cid = ($urandom_range(0, 99) < 88) ? 16'(cb + $urandom_range(0, CELLS - 1))
                                         : 16'($urandom);
      if ($urandom_range(0, 1)) begin
        x = 24'($urandom); y = 24'($urandom); z = 24'($urandom); d = 23'($urandom);
      end else begin
        x = 24'($urandom_range(0, 8191) - 4096);
        y = 24'($urandom_range(0, 8191) - 4096);
        z = 24'($urandom_range(0, 8191) - 4096);
        d = 23'($urandom_range(0, 8191));
      end
      send_word(op, zid, cid, whole, x, y, z, d);
    end
  endtask

  task automatic test_random();
    random_phase(16'd0, 16'd0, 300);
    random_phase(16'hFFFF, 16'hFFFF, 200);
    random_phase(16'hFFF0, 16'hFFC0, 300);
    random_phase(16'($urandom), 16'($urandom), 250);
    random_phase(16'd7, 16'd1000, 250);
    random_phase(16'd0, 16'd0, 200);
    drain();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_windows_and_extremes();
    test_random();
    drain();
    repeat (300) @(posedge clk);
    $display("Covered %0d accumulates and %0d queries under eight window settings, %0d checked.",
             n_acc, n_query, n_checked);
    $display("Out-of-window words: %0d, count-full words: %0d.", n_range, n_full);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
